FILE: hw/rtl/asew_pkg.sv
package asew_pkg;

	// fixed-point constants
	localparam logic [31:0] FIX_ONE   = 32'h0001_0000;
	localparam logic [31:0] FIX_FRAC  = 32'h0000_FFFF;
	localparam logic [47:0] RECIP_NUM = 48'h0000_4000_0000;

	// divider: one quotient bit per cycle over a 48 bit dividend
	localparam int DIV_BITS = 48;
	localparam int CNT_W    = $clog2(DIV_BITS + 1);

	// item functions
	localparam logic [1:0] FUNC_LEFT  = 2'd0;
	localparam logic [1:0] FUNC_RIGHT = 2'd1;
	localparam logic [1:0] FUNC_ROW   = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// accumulator lanes
	localparam int          LANES    = 5;
	localparam logic [2:0]  LANE_LX  = 3'd0;
	localparam logic [2:0]  LANE_LU  = 3'd1;
	localparam logic [2:0]  LANE_LV  = 3'd2;
	localparam logic [2:0]  LANE_LF  = 3'd3;
	localparam logic [2:0]  LANE_RX  = 3'd4;

	// register indices (byte address bits 4:2)
	localparam int          PADDR_W      = 5;
	localparam logic [2:0]  REG_U_GRAD   = 3'd0;
	localparam logic [2:0]  REG_V_GRAD   = 3'd1;
	localparam logic [2:0]  REG_FOG_GRAD = 3'd2;
	localparam logic [2:0]  REG_CLIP_L   = 3'd3;
	localparam logic [2:0]  REG_CLIP_R   = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] x_a;
		logic signed [31:0] y_a;
		logic signed [31:0] u_a;
		logic signed [31:0] v_a;
		logic [7:0]         fog_a;
		logic signed [31:0] x_b;
		logic signed [31:0] y_b;
		logic signed [31:0] u_b;
		logic signed [31:0] v_b;
		logic [7:0]         fog_b;
	} in_item_t;

	typedef struct packed {
		logic               span_valid;
		logic signed [15:0] x_start;
		logic [15:0]        span_length;
		logic signed [31:0] u_start;
		logic signed [31:0] v_start;
		logic signed [31:0] fog_start;
	} out_item_t;

	typedef struct packed {
		logic [31:0] u_grad;
		logic [31:0] v_grad;
		logic [31:0] fog_grad;
		logic [15:0] clip_left;
		logic [15:0] clip_right;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV_START,
		OP_RECIP_MUL,
		OP_SLOPE_WR,
		OP_PRE_MUL,
		OP_ACC_WR,
		OP_ROW_PREP,
		OP_ROW_MUL,
		OP_ROW_WR,
		OP_ROW_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] lane;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_busy;
	} status_t;

endpackage

FILE: hw/rtl/affine_span_edge_walker.sv
// row item: result waits for a free output, then the next item is taken
// edge item: each slope runs the 48 step shared divider, then the multiplier;
//   left edge four slopes (x, u, v, fog), right edge one (x)
// one item at a time; a finished span waits in the output register
// reset: asynchronous, active low; clears registers, slopes and accumulators
module affine_span_edge_walker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  asew_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output asew_pkg::out_item_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [asew_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	asew_pkg::cfg_t    cfg;
	asew_pkg::cmd_t    cmd;
	asew_pkg::status_t status;

	// configuration registers
	asew_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	asew_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (in_data.func),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	asew_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_valid && in_ready),
		.in_data   (in_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: hw/rtl/asew_regs.sv
module asew_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [asew_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output asew_pkg::cfg_t                  cfg
);

	asew_pkg::cfg_t cfg_q;
	logic [2:0]     idx;

	assign idx    = paddr[asew_pkg::PADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				asew_pkg::REG_U_GRAD:   cfg_q.u_grad     <= pwdata;
				asew_pkg::REG_V_GRAD:   cfg_q.v_grad     <= pwdata;
				asew_pkg::REG_FOG_GRAD: cfg_q.fog_grad   <= pwdata;
				asew_pkg::REG_CLIP_L:   cfg_q.clip_left  <= pwdata[15:0];
				asew_pkg::REG_CLIP_R:   cfg_q.clip_right <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			asew_pkg::REG_U_GRAD:   prdata = cfg_q.u_grad;
			asew_pkg::REG_V_GRAD:   prdata = cfg_q.v_grad;
			asew_pkg::REG_FOG_GRAD: prdata = cfg_q.fog_grad;
			asew_pkg::REG_CLIP_L:   prdata = {16'h0, cfg_q.clip_left};
			asew_pkg::REG_CLIP_R:   prdata = {16'h0, cfg_q.clip_right};
			default:                prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/asew_ctrl.sv
module asew_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  asew_pkg::status_t   status,
	output asew_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_RECIP_MUL,
		S_SLOPE_WR,
		S_PRE_MUL,
		S_ACC_WR,
		S_ROW_PREP,
		S_ROW_MUL,
		S_ROW_WR,
		S_ROW_DONE
	} state_t;

	state_t         state_q;
	asew_pkg::cmd_t cmd_q;

	assign in_ready = (state_q == S_IDLE);
	assign cmd      = cmd_q;

	// sequencer: state and registered command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '{op: asew_pkg::OP_NONE, lane: '0};
		end else begin
			cmd_q.op <= asew_pkg::OP_NONE;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (func)
							asew_pkg::FUNC_LEFT: begin
								state_q   <= S_DIV_GO;
								cmd_q     <= '{op: asew_pkg::OP_DIV_START,
									lane: asew_pkg::LANE_LX};
							end
							asew_pkg::FUNC_RIGHT: begin
								state_q   <= S_DIV_GO;
								cmd_q     <= '{op: asew_pkg::OP_DIV_START,
									lane: asew_pkg::LANE_RX};
							end
							asew_pkg::FUNC_ROW: begin
								state_q   <= S_ROW_PREP;
								cmd_q     <= '{op: asew_pkg::OP_ROW_PREP, lane: '0};
							end
							default: ;
						endcase
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (!status.div_busy) begin
						state_q  <= S_RECIP_MUL;
						cmd_q.op <= asew_pkg::OP_RECIP_MUL;
					end
				end
				S_RECIP_MUL: begin
					state_q  <= S_SLOPE_WR;
					cmd_q.op <= asew_pkg::OP_SLOPE_WR;
				end
				S_SLOPE_WR: begin
					state_q  <= S_PRE_MUL;
					cmd_q.op <= asew_pkg::OP_PRE_MUL;
				end
				S_PRE_MUL: begin
					state_q  <= S_ACC_WR;
					cmd_q.op <= asew_pkg::OP_ACC_WR;
				end
				S_ACC_WR: begin
					if (cmd_q.lane == asew_pkg::LANE_LF || cmd_q.lane == asew_pkg::LANE_RX) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV_GO;
						cmd_q   <= '{op: asew_pkg::OP_DIV_START, lane: cmd_q.lane + 3'd1};
					end
				end
				S_ROW_PREP: begin
					state_q <= S_ROW_MUL;
					cmd_q   <= '{op: asew_pkg::OP_ROW_MUL, lane: '0};
				end
				S_ROW_MUL: begin
					state_q  <= S_ROW_WR;
					cmd_q.op <= asew_pkg::OP_ROW_WR;
				end
				S_ROW_WR: begin
					if (cmd_q.lane == 3'd2) begin
						state_q <= S_ROW_DONE;
					end else begin
						state_q <= S_ROW_MUL;
						cmd_q   <= '{op: asew_pkg::OP_ROW_MUL, lane: cmd_q.lane + 3'd1};
					end
				end
				S_ROW_DONE: begin
					if (!status.out_busy) begin
						state_q  <= S_IDLE;
						cmd_q.op <= asew_pkg::OP_ROW_FINISH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/asew_dp.sv
module asew_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  asew_pkg::in_item_t   in_data,
	input  asew_pkg::cfg_t       cfg,
	input  asew_pkg::cmd_t       cmd,
	output asew_pkg::status_t    status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output asew_pkg::out_item_t  out_data
);

	asew_pkg::in_item_t  item_q;
	logic [31:0]         dy_q;
	logic [31:0]         sub_q;
	logic                recip_q;
	logic                dy_zero_q;

	logic [31:0]         step_q [asew_pkg::LANES];
	logic [31:0]         acc_q  [asew_pkg::LANES];

	logic [31:0]         rem_q;
	logic [47:0]         quo_q;
	logic [31:0]         dvs_q;
	logic                neg_q;
	logic                busy_q;
	logic [asew_pkg::CNT_W-1:0] cnt_q;

	logic signed [63:0]  prod_q;

	logic signed [15:0]  xl_q;
	logic [15:0]         len_q;
	logic                valid_q;
	logic [31:0]         hs_q;
	logic [31:0]         res_q [3];

	logic                out_valid_q;
	asew_pkg::out_item_t out_q;

	logic [31:0] fa, fb, dnum, base, q32, n_mag, grad;
	logic [31:0] dy_in, y_ceil;
	logic [32:0] rem_sh;
	logic [31:0] mul_a, mul_b;
	logic [31:0] lx_ceil, rx_ceil;
	logic signed [15:0] xl0, xr0, xl, xr, cl, cr;
	logic signed [16:0] len17;
	logic        clip_on;

	assign status.div_busy = busy_q;
	assign status.out_busy = out_valid_q;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	// lane operand selection
	assign fa = {8'h0, item_q.fog_a, 16'h0};
	assign fb = {8'h0, item_q.fog_b, 16'h0};
	always_comb begin
		case (cmd.lane)
			asew_pkg::LANE_LU: begin
				dnum = item_q.u_b - item_q.u_a;
				base = item_q.u_a;
			end
			asew_pkg::LANE_LV: begin
				dnum = item_q.v_b - item_q.v_a;
				base = item_q.v_a;
			end
			asew_pkg::LANE_LF: begin
				dnum = fb - fa;
				base = fa;
			end
			default: begin
				dnum = item_q.x_b - item_q.x_a;
				base = item_q.x_a;
			end
		endcase
		case (cmd.lane)
			3'd1:    grad = cfg.v_grad;
			3'd2:    grad = cfg.fog_grad;
			default: grad = cfg.u_grad;
		endcase
	end

	// accepted item capture, dy and prestep
	assign dy_in  = in_data.y_b - in_data.y_a;
	assign y_ceil = in_data.y_a + asew_pkg::FIX_FRAC;
	always_ff @(posedge clk) begin
		if (load) begin
			item_q    <= in_data;
			dy_q      <= dy_in;
			recip_q   <= !($signed(dy_in) >= $signed(asew_pkg::FIX_ONE));
			dy_zero_q <= (dy_in == '0);
			sub_q     <= {y_ceil[31:16], 16'h0} - in_data.y_a;
		end
	end

	// signed quotient, low 32 bits
	assign n_mag = dnum[31] ? (32'h0 - dnum) : dnum;
	always_comb begin
		q32 = neg_q ? (32'h0 - quo_q[31:0]) : quo_q[31:0];
		if (recip_q && dy_zero_q) begin
			q32 = '0;
		end
	end

	// restoring divider, one bit per cycle
	assign rem_sh = {rem_q, quo_q[47]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.op == asew_pkg::OP_DIV_START) begin
			busy_q <= 1'b1;
			cnt_q  <= asew_pkg::CNT_W'(asew_pkg::DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == asew_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == asew_pkg::OP_DIV_START) begin
			rem_q <= '0;
			if (recip_q) begin
				quo_q <= asew_pkg::RECIP_NUM;
				dvs_q <= dy_q[31] ? (32'h0 - dy_q) : dy_q;
				neg_q <= dy_q[31];
			end else begin
				quo_q <= {n_mag, 16'h0};
				dvs_q <= dy_q;
				neg_q <= dnum[31];
			end
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= 32'(rem_sh - {1'b0, dvs_q});
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	// shared multiplier
	always_comb begin
		case (cmd.op)
			asew_pkg::OP_RECIP_MUL: begin
				mul_a = q32;
				mul_b = dnum;
			end
			asew_pkg::OP_PRE_MUL: begin
				mul_a = step_q[cmd.lane];
				mul_b = sub_q;
			end
			asew_pkg::OP_ROW_MUL: begin
				mul_a = grad;
				mul_b = hs_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= $signed(mul_a) * $signed(mul_b);
	end

	// span start, clamp and length
	assign lx_ceil = acc_q[asew_pkg::LANE_LX] + asew_pkg::FIX_FRAC;
	assign rx_ceil = acc_q[asew_pkg::LANE_RX] + asew_pkg::FIX_FRAC;
	assign xl0     = $signed(lx_ceil[31:16]);
	assign xr0     = $signed(rx_ceil[31:16]);
	assign cl      = $signed(cfg.clip_left);
	assign cr      = $signed(cfg.clip_right);
	assign clip_on = cr > cl;
	assign xl      = (clip_on && xl0 < cl) ? cl : xl0;
	assign xr      = (clip_on && xr0 > cr) ? cr : xr0;
	assign len17   = {xr[15], xr} - {xl[15], xl};

	always_ff @(posedge clk) begin
		if (cmd.op == asew_pkg::OP_ROW_PREP) begin
			xl_q    <= xl;
			len_q   <= len17[15:0];
			valid_q <= !len17[16] && (len17 != '0);
			hs_q    <= {xl, 16'h0} - acc_q[asew_pkg::LANE_LX];
		end
		if (cmd.op == asew_pkg::OP_ROW_WR) begin
			res_q[cmd.lane[1:0]] <= valid_q
				? acc_q[cmd.lane + 3'd1] + prod_q[47:16] : '0;
		end
	end

	// slopes and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < asew_pkg::LANES; i++) begin
				step_q[i] <= '0;
				acc_q[i]  <= '0;
			end
		end else begin
			case (cmd.op)
				asew_pkg::OP_SLOPE_WR:
					step_q[cmd.lane] <= recip_q ? prod_q[45:14] : q32;
				asew_pkg::OP_ACC_WR:
					acc_q[cmd.lane] <= base + prod_q[47:16];
				asew_pkg::OP_ROW_FINISH: begin
					for (int i = 0; i < asew_pkg::LANES; i++) begin
						acc_q[i] <= acc_q[i] + step_q[i];
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == asew_pkg::OP_ROW_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == asew_pkg::OP_ROW_FINISH) begin
			out_q.span_valid  <= valid_q;
			out_q.x_start     <= xl_q;
			out_q.span_length <= valid_q ? len_q : '0;
			out_q.u_start     <= res_q[0];
			out_q.v_start     <= res_q[1];
			out_q.fog_start   <= res_q[2];
		end
	end

endmodule

FILE: hw/rtl/asew_checker.sv
module asew_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  asew_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  asew_pkg::out_item_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [asew_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	input  logic [31:0]                     prdata
);

	// a result held back stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a real item keeps the block busy for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.func != asew_pkg::FUNC_NONE |=> !in_ready)
		else $error("input taken again straight after an item");

	// written gradient reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == '0)
		##1 (psel && !pwrite && paddr == '0) |-> prdata == $past(pwdata))
		else $error("register read back differs from write");

endmodule

bind affine_span_edge_walker asew_checker u_asew_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
